[rtl/sdb_pkg.sv]
`default_nettype none
package sdb_pkg;

    localparam int RING_DEPTH = 8192;
    localparam int RING_AW    = 13;
    localparam int MAX_BINS   = 64;
    localparam int BIN_AW     = 6;
    localparam int SINE_DEPTH = 1024;
    localparam int SINE_AW    = 10;
    localparam int ACC_W      = 40;
    localparam int SQ_W       = 80;
    localparam int SQ_STEPS   = 6;
    localparam int ROOT_STEPS = 40;

    localparam logic [1:0] OP_SAMPLE = 2'd0;
    localparam logic [1:0] OP_LOAD   = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;
    localparam logic [1:0] OP_CLEAR  = 2'd3;

    localparam logic CFG_ACTIVE_BINS = 1'b0;
    localparam logic CFG_LEAK        = 1'b1;

    localparam logic [16:0] LEAK_UNITY = 17'd65536;

    localparam logic signed [43:0] ACC_MAX = 44'sd549755813887;
    localparam logic signed [43:0] ACC_MIN = -44'sd549755813888;

    typedef struct packed {
        logic [1:0]         opcode;
        logic signed [15:0] sample_value;
        logic [5:0]         bin_select;
        logic [31:0]        phase_step;
        logic [15:0]        bin_gain;
        logic [12:0]        win_len;
    } t_in_word;

    typedef struct packed {
        logic [5:0]  bin_echo;
        logic [39:0] magnitude;
    } t_out_word;

    typedef enum logic [3:0] {
        ST_NONE,
        ST_BIN_RD,
        ST_BIN_TRIG,
        ST_BIN_MUL,
        ST_BIN_TERM,
        ST_BIN_WR,
        ST_SMP_END,
        ST_LOAD,
        ST_CLEAR,
        ST_MAG_RD,
        ST_MAG_ABS,
        ST_MAG_SQ,
        ST_MAG_INIT,
        ST_MAG_ITER,
        ST_MAG_OUT
    } t_step;

    typedef struct packed {
        t_step       step;
        logic        take;
        logic [5:0]  bin;
        logic [5:0]  cnt;
    } t_cmd;

    typedef struct packed {
        logic [31:0] step;
        logic [15:0] gain;
        logic [12:0] window;
        logic [31:0] back;
    } t_tab_entry;

    typedef struct packed {
        logic [31:0]        phase;
        logic signed [39:0] re;
        logic signed [39:0] im;
    } t_run_entry;

    localparam t_tab_entry TAB_RESET = '{step: 32'd0, gain: 16'd0, window: 13'd1, back: 32'd0};
    localparam t_run_entry RUN_RESET = '{phase: 32'd0, re: 40'sd0, im: 40'sd0};

    typedef logic signed [15:0] t_trig_tab [SINE_DEPTH];

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned SERIES_DIV [8] = '{6, 20, 42, 72, 110, 156, 210, 272};

    // sin of u * (pi/2) / SINE_DEPTH in Q1.15, by a Taylor series in Q2.30
    function automatic logic signed [15:0] trig_q15(input logic [31:0] u);
        logic [1:0]  q;
        logic [63:0] r;
        logic [63:0] th;
        logic [63:0] th2;
        logic [63:0] t;
        logic [63:0] v;
        longint      sum;
        int          n;
        q = u[SINE_AW+1:SINE_AW];
        r = 64'(u[SINE_AW-1:0]);
        if (q[0]) begin
            r = 64'(SINE_DEPTH) - r;
        end
        th  = (r * HALF_PI_Q30) / SINE_DEPTH;
        th2 = (th * th) >> 30;
        t   = th;
        sum = longint'(th);
        for (n = 1; n <= 8; n++) begin
            t = ((t * th2) >> 30) / SERIES_DIV[n-1];
            if ((n & 1) != 0) begin
                sum = sum - longint'(t);
            end else begin
                sum = sum + longint'(t);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        v = (64'(sum) + 64'd16384) >> 15;
        if (v > 64'd32767) begin
            v = 64'd32767;
        end
        return q[1] ? -16'(v) : 16'(v);
    endfunction

    function automatic t_trig_tab build_tab(input logic is_cos);
        t_trig_tab tab;
        int        k;
        for (k = 0; k < SINE_DEPTH; k++) begin
            tab[k] = trig_q15(32'(4 * k) + (is_cos ? 32'(SINE_DEPTH) : 32'd0));
        end
        return tab;
    endfunction

    localparam t_trig_tab SIN_TAB = build_tab(1'b0);
    localparam t_trig_tab COS_TAB = build_tab(1'b1);

endpackage
`default_nettype wire

[rtl/sliding_dft_bin_bank.sv]
// Sliding-window DFT bin bank over signed Q1.15 audio, 64 bins with 40-bit accumulators.
// A sample word takes every bin through read, trig, multiply, term and write on one shared
// multiply datapath for all 64 bins (phases of inactive bins still advance), plus accept and
// ring update. A read word forms six 20x20 partial products for re^2 + im^2 and runs a
// 40-step bit-serial square root. The result register lets the next word in while a
// magnitude waits. The 8192-entry sample ring is not cleared.
`default_nettype none
module sliding_dft_bin_bank (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire sdb_pkg::t_in_word  i_in,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output sdb_pkg::t_out_word      o_out,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic               i_cfg_index,
    input  wire logic [16:0]        i_cfg_data
);
    import sdb_pkg::*;

    t_cmd cmd;
    logic out_busy;

    assign o_cfg_ready = 1'b1;

    sdb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_opcode   (i_in.opcode),
        .i_out_busy (out_busy),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    sdb_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in        (i_in),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .o_out_valid (o_out_valid),
        .o_out_busy  (out_busy)
    );

    a_mag_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.step == ST_MAG_OUT |-> !out_busy)
        else $error("magnitude written into a full output slot");

    a_sample_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_in.opcode == OP_SAMPLE)
        |=> (cmd.step == ST_BIN_RD && cmd.bin == '0))
        else $error("sample sweep did not start at the first bin");

    a_sweep_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.step == ST_SMP_END
        |-> ($past(cmd.step) == ST_BIN_WR && $past(cmd.bin) == 6'(MAX_BINS - 1)))
        else $error("ring advanced before the last bin was written");

endmodule
`default_nettype wire

[rtl/sdb_ram.sv]
`default_nettype none
module sdb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

[rtl/sdb_ctrl.sv]
`default_nettype none
module sdb_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire logic [1:0]    i_opcode,
    input  wire logic          i_out_busy,
    output logic               o_in_ready,
    output sdb_pkg::t_cmd      o_cmd
);
    import sdb_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_BIN_RD,
        S_BIN_TRIG,
        S_BIN_MUL,
        S_BIN_TERM,
        S_BIN_WR,
        S_SMP_END,
        S_LOAD,
        S_CLEAR,
        S_MAG_RD,
        S_MAG_ABS,
        S_MAG_SQ,
        S_MAG_INIT,
        S_MAG_ITER,
        S_MAG_OUT
    } t_state;

    t_state     r_state;
    logic [5:0] r_bin;
    logic [5:0] r_cnt;
    logic       take;

    assign o_in_ready = (r_state == S_IDLE);
    assign take       = i_in_valid && (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_bin   <= '0;
            r_cnt   <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    r_bin <= '0;
                    r_cnt <= '0;
                    if (i_in_valid) begin
                        case (i_opcode)
                            OP_SAMPLE: r_state <= S_BIN_RD;
                            OP_LOAD:   r_state <= S_LOAD;
                            OP_READ:   r_state <= S_MAG_RD;
                            OP_CLEAR:  r_state <= S_CLEAR;
                            default:   r_state <= S_IDLE;
                        endcase
                    end
                end
                S_BIN_RD:   r_state <= S_BIN_TRIG;
                S_BIN_TRIG: r_state <= S_BIN_MUL;
                S_BIN_MUL:  r_state <= S_BIN_TERM;
                S_BIN_TERM: r_state <= S_BIN_WR;
                S_BIN_WR: begin
                    if (r_bin == 6'(MAX_BINS - 1)) begin
                        r_state <= S_SMP_END;
                    end else begin
                        r_bin   <= r_bin + 6'd1;
                        r_state <= S_BIN_RD;
                    end
                end
                S_SMP_END: r_state <= S_IDLE;
                S_LOAD:    r_state <= S_IDLE;
                S_CLEAR:   r_state <= S_IDLE;
                S_MAG_RD:  r_state <= S_MAG_ABS;
                S_MAG_ABS: r_state <= S_MAG_SQ;
                S_MAG_SQ: begin
                    if (r_cnt == 6'(SQ_STEPS - 1)) begin
                        r_cnt   <= '0;
                        r_state <= S_MAG_INIT;
                    end else begin
                        r_cnt <= r_cnt + 6'd1;
                    end
                end
                S_MAG_INIT: r_state <= S_MAG_ITER;
                S_MAG_ITER: begin
                    if (r_cnt == 6'(ROOT_STEPS - 1)) begin
                        r_state <= S_MAG_OUT;
                    end else begin
                        r_cnt <= r_cnt + 6'd1;
                    end
                end
                S_MAG_OUT: begin
                    // hold until the output slot frees up
                    if (!i_out_busy) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_comb begin
        o_cmd.take = take;
        o_cmd.bin  = r_bin;
        o_cmd.cnt  = r_cnt;
        case (r_state)
            S_BIN_RD:   o_cmd.step = ST_BIN_RD;
            S_BIN_TRIG: o_cmd.step = ST_BIN_TRIG;
            S_BIN_MUL:  o_cmd.step = ST_BIN_MUL;
            S_BIN_TERM: o_cmd.step = ST_BIN_TERM;
            S_BIN_WR:   o_cmd.step = ST_BIN_WR;
            S_SMP_END:  o_cmd.step = ST_SMP_END;
            S_LOAD:     o_cmd.step = ST_LOAD;
            S_CLEAR:    o_cmd.step = ST_CLEAR;
            S_MAG_RD:   o_cmd.step = ST_MAG_RD;
            S_MAG_ABS:  o_cmd.step = ST_MAG_ABS;
            S_MAG_SQ:   o_cmd.step = ST_MAG_SQ;
            S_MAG_INIT: o_cmd.step = ST_MAG_INIT;
            S_MAG_ITER: o_cmd.step = ST_MAG_ITER;
            S_MAG_OUT:  o_cmd.step = i_out_busy ? ST_NONE : ST_MAG_OUT;
            default:    o_cmd.step = ST_NONE;
        endcase
    end

endmodule
`default_nettype wire

[rtl/sdb_dp.sv]
`default_nettype none
module sdb_dp (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire sdb_pkg::t_cmd     i_cmd,
    input  wire sdb_pkg::t_in_word i_in,
    input  wire logic              i_cfg_we,
    input  wire logic              i_cfg_index,
    input  wire logic [16:0]       i_cfg_data,
    input  wire logic              i_out_ready,
    output sdb_pkg::t_out_word     o_out,
    output logic                   o_out_valid,
    output logic                   o_out_busy
);
    import sdb_pkg::*;

    // control state
    logic [RING_AW-1:0]  r_wpos;
    logic [RING_AW-1:0]  r_filled;
    logic [6:0]          r_active;
    logic [16:0]         r_leak;
    logic [MAX_BINS-1:0] r_tab_vld;
    logic [MAX_BINS-1:0] r_run_vld;
    logic                r_out_vld;

    // payload
    t_in_word            r_in;
    t_tab_entry          r_tab;
    t_run_entry          r_run;
    logic signed [15:0]  r_cn, r_sn, r_co, r_so;
    logic                r_rm;
    logic signed [31:0]  r_p0, r_p1, r_p2, r_p3;
    logic signed [41:0]  r_lr, r_li;
    logic signed [17:0]  r_t0, r_t1, r_t2, r_t3;
    logic [39:0]         r_ar, r_ai;
    logic [SQ_W-1:0]     r_sq, r_op, r_res, r_one;
    t_out_word           r_out;

    // memories
    logic [RING_AW-1:0]  ring_raddr;
    logic [15:0]         ring_rdata;
    t_tab_entry          tab_rdata, tab_wdata, tab_e;
    t_run_entry          run_rdata, run_wdata, run_e;
    logic [BIN_AW-1:0]   run_raddr;
    logic                tab_we, run_we, ring_we;

    logic [16:0]         leak_eff;
    logic [12:0]         load_w;
    logic                bin_active;
    logic [31:0]         old_phase;
    logic signed [43:0]  sum_re, sum_im;
    logic [19:0]         sq_a, sq_b;
    logic [1:0]          sq_sel;
    logic [39:0]         sq_prod;
    logic [SQ_W-1:0]     sq_add, trial;

    function automatic logic signed [17:0] rterm(input logic signed [31:0] p,
                                                 input logic [15:0] g);
        logic signed [48:0] x;
        x = 49'(p) * 49'($signed({1'b0, g}));
        x = x + 49'sd1073741824;
        return x[48:31];
    endfunction

    function automatic logic signed [41:0] rleak(input logic signed [39:0] a,
                                                 input logic [16:0] l);
        logic signed [57:0] x;
        x = 58'(a) * 58'($signed({1'b0, l}));
        x = x + 58'sd32768;
        return x[57:16];
    endfunction

    function automatic logic signed [39:0] sat40(input logic signed [43:0] x);
        logic signed [43:0] y;
        y = x;
        if (x > ACC_MAX) begin
            y = ACC_MAX;
        end else if (x < ACC_MIN) begin
            y = ACC_MIN;
        end
        return y[39:0];
    endfunction

    assign tab_e    = r_tab_vld[i_cmd.bin] ? tab_rdata : TAB_RESET;
    assign run_e    = r_run_vld[run_raddr] ? run_rdata : RUN_RESET;
    assign leak_eff = (r_leak > LEAK_UNITY) ? LEAK_UNITY : r_leak;
    assign load_w   = (r_in.win_len == 13'd0) ? 13'd1 : r_in.win_len;
    assign bin_active = ({1'b0, i_cmd.bin} < r_active);
    assign old_phase  = run_e.phase - tab_e.back;

    assign run_raddr  = (i_cmd.step == ST_MAG_RD || i_cmd.step == ST_MAG_ABS)
                        ? r_in.bin_select : i_cmd.bin;
    assign ring_raddr = r_wpos - tab_e.window;

    assign tab_we  = (i_cmd.step == ST_LOAD);
    assign run_we  = (i_cmd.step == ST_BIN_WR);
    assign ring_we = (i_cmd.step == ST_SMP_END);

    assign tab_wdata.step   = r_in.phase_step;
    assign tab_wdata.gain   = r_in.bin_gain;
    assign tab_wdata.window = load_w;
    assign tab_wdata.back   = 32'(r_in.phase_step * 32'(load_w));

    assign sum_re = 44'(r_lr) + 44'(r_t0) - (r_rm ? 44'(r_t2) : 44'sd0);
    assign sum_im = 44'(r_li) - 44'(r_t1) + (r_rm ? 44'(r_t3) : 44'sd0);

    assign run_wdata.phase = r_run.phase + r_tab.step;
    assign run_wdata.re    = bin_active ? sat40(sum_re) : r_run.re;
    assign run_wdata.im    = bin_active ? sat40(sum_im) : r_run.im;

    sdb_ram #(.WIDTH(16), .DEPTH(RING_DEPTH)) u_ring (
        .i_clk   (i_clk),
        .i_we    (ring_we),
        .i_waddr (r_wpos),
        .i_wdata (r_in.sample_value),
        .i_raddr (ring_raddr),
        .o_rdata (ring_rdata)
    );

    sdb_ram #(.WIDTH($bits(t_tab_entry)), .DEPTH(MAX_BINS)) u_tab (
        .i_clk   (i_clk),
        .i_we    (tab_we),
        .i_waddr (r_in.bin_select),
        .i_wdata (tab_wdata),
        .i_raddr (i_cmd.bin),
        .o_rdata (tab_rdata)
    );

    sdb_ram #(.WIDTH($bits(t_run_entry)), .DEPTH(MAX_BINS)) u_run (
        .i_clk   (i_clk),
        .i_we    (run_we),
        .i_waddr (i_cmd.bin),
        .i_wdata (run_wdata),
        .i_raddr (run_raddr),
        .o_rdata (run_rdata)
    );

    // one 20x20 partial product of re^2 + im^2 per step
    always_comb begin
        sq_a   = '0;
        sq_b   = '0;
        sq_sel = 2'd2;
        case (i_cmd.cnt)
            6'd0: begin sq_a = r_ar[39:20]; sq_b = r_ar[39:20]; sq_sel = 2'd0; end
            6'd1: begin sq_a = r_ar[39:20]; sq_b = r_ar[19:0];  sq_sel = 2'd1; end
            6'd2: begin sq_a = r_ar[19:0];  sq_b = r_ar[19:0];  sq_sel = 2'd2; end
            6'd3: begin sq_a = r_ai[39:20]; sq_b = r_ai[39:20]; sq_sel = 2'd0; end
            6'd4: begin sq_a = r_ai[39:20]; sq_b = r_ai[19:0];  sq_sel = 2'd1; end
            6'd5: begin sq_a = r_ai[19:0];  sq_b = r_ai[19:0];  sq_sel = 2'd2; end
            default: begin sq_a = '0; sq_b = '0; sq_sel = 2'd2; end
        endcase
        sq_prod = 40'(sq_a) * 40'(sq_b);
        case (sq_sel)
            2'd0:    sq_add = {sq_prod, 40'd0};
            2'd1:    sq_add = {19'd0, sq_prod, 21'd0};
            default: sq_add = {40'd0, sq_prod};
        endcase
    end

    assign trial = r_res + r_one;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wpos    <= '0;
            r_filled  <= '0;
            r_active  <= 7'd64;
            r_leak    <= LEAK_UNITY;
            r_tab_vld <= '0;
            r_run_vld <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_ACTIVE_BINS: r_active <= i_cfg_data[6:0];
                    CFG_LEAK:        r_leak   <= i_cfg_data;
                    default:         r_leak   <= r_leak;
                endcase
            end
            case (i_cmd.step)
                ST_BIN_WR: r_run_vld[i_cmd.bin] <= 1'b1;
                ST_SMP_END: begin
                    r_wpos <= r_wpos + RING_AW'(1);
                    if (r_filled != RING_AW'(RING_DEPTH - 1)) begin
                        r_filled <= r_filled + RING_AW'(1);
                    end
                end
                ST_LOAD: begin
                    r_tab_vld[r_in.bin_select] <= 1'b1;
                    r_run_vld[r_in.bin_select] <= 1'b0;
                end
                ST_CLEAR: begin
                    r_wpos    <= '0;
                    r_filled  <= '0;
                    r_run_vld <= '0;
                end
                default: r_wpos <= r_wpos;
            endcase
            if (i_cmd.step == ST_MAG_OUT) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_in <= i_in;
        end
        case (i_cmd.step)
            ST_BIN_TRIG: begin
                r_tab <= tab_e;
                r_run <= run_e;
                r_cn  <= COS_TAB[run_e.phase[31:32-SINE_AW]];
                r_sn  <= SIN_TAB[run_e.phase[31:32-SINE_AW]];
                r_co  <= COS_TAB[old_phase[31:32-SINE_AW]];
                r_so  <= SIN_TAB[old_phase[31:32-SINE_AW]];
                r_rm  <= (r_filled >= tab_e.window);
            end
            ST_BIN_MUL: begin
                r_p0 <= 32'(r_in.sample_value) * 32'(r_cn);
                r_p1 <= 32'(r_in.sample_value) * 32'(r_sn);
                r_p2 <= 32'($signed(ring_rdata)) * 32'(r_co);
                r_p3 <= 32'($signed(ring_rdata)) * 32'(r_so);
                r_lr <= rleak(r_run.re, leak_eff);
                r_li <= rleak(r_run.im, leak_eff);
            end
            ST_BIN_TERM: begin
                r_t0 <= rterm(r_p0, r_tab.gain);
                r_t1 <= rterm(r_p1, r_tab.gain);
                r_t2 <= rterm(r_p2, r_tab.gain);
                r_t3 <= rterm(r_p3, r_tab.gain);
            end
            ST_MAG_ABS: begin
                r_ar <= run_e.re[39] ? 40'(-run_e.re) : 40'(run_e.re);
                r_ai <= run_e.im[39] ? 40'(-run_e.im) : 40'(run_e.im);
                r_sq <= '0;
            end
            ST_MAG_SQ: r_sq <= r_sq + sq_add;
            ST_MAG_INIT: begin
                r_op  <= r_sq;
                r_res <= '0;
                r_one <= SQ_W'(1) << (SQ_W - 2);
            end
            ST_MAG_ITER: begin
                if (r_op >= trial) begin
                    r_op  <= r_op - trial;
                    r_res <= (r_res >> 1) + r_one;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_one <= r_one >> 2;
            end
            ST_MAG_OUT: begin
                r_out.bin_echo  <= r_in.bin_select;
                r_out.magnitude <= r_res[39:0];
            end
            default: r_op <= r_op;
        endcase
    end

    assign o_out       = r_out;
    assign o_out_valid = r_out_vld;
    assign o_out_busy  = r_out_vld && !i_out_ready;

endmodule
`default_nettype wire

[tb/tb_sliding_dft_bin_bank.sv]
`timescale 1ns / 100ps
`default_nettype none
module tb_sliding_dft_bin_bank;
    import sdb_pkg::*;

    localparam int  SETTLE_CYCLES = 400;
    localparam int  CYCLE_LIMIT   = 3000000;
    localparam longint BANK_MAX   = 64'sd549755813887;
    localparam longint BANK_MIN   = -64'sd549755813888;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    t_in_word    i_in;
    logic        o_out_valid;
    logic        i_out_ready;
    t_out_word   o_out;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic        i_cfg_index;
    logic [16:0] i_cfg_data;

    sliding_dft_bin_bank u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    // bin bank mirror
    logic signed [15:0] sin_lut [SINE_DEPTH];
    logic signed [15:0] cos_lut [SINE_DEPTH];
    logic signed [15:0] audio_ring [RING_DEPTH];
    int unsigned write_pos;
    int unsigned fill_count;
    logic [6:0]  num_active;
    logic [16:0] leak_q16;
    int unsigned phase_acc   [MAX_BINS];
    int unsigned phase_inc   [MAX_BINS];
    logic [15:0] gain_tab    [MAX_BINS];
    int unsigned win_tab     [MAX_BINS];
    int unsigned back_phase  [MAX_BINS];
    longint      real_sum    [MAX_BINS];
    longint      imag_sum    [MAX_BINS];

    t_in_word  pending_words [$];
    t_out_word magnitudes_due [$];
    int  send_idle_pct;
    int  recv_stall_pct;
    bit  in_taken;
    int  error_count;
    int  cycle_count;

    // quarter-wave Taylor series, Q2.30 angle, Q1.15 result
    function automatic logic signed [15:0] sine_q15(input int unsigned u);
        longint unsigned quad, rem, th, th2, t, v;
        longint sum;
        int n;
        quad = (u / SINE_DEPTH) % 4;
        rem  = u % SINE_DEPTH;
        if (quad % 2 == 1) begin
            rem = SINE_DEPTH - rem;
        end
        th  = (rem * 64'd1686629713) / SINE_DEPTH;
        th2 = (th * th) >> 30;
        t   = th;
        sum = longint'(th);
        for (n = 1; n <= 8; n++) begin
            t = ((t * th2) >> 30) / longint'((2 * n) * (2 * n + 1));
            if (n % 2 == 1) begin
                sum = sum - longint'(t);
            end else begin
                sum = sum + longint'(t);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        v = (longint'(sum) + 16384) >> 15;
        if (v > 32767) begin
            v = 32767;
        end
        return (quad >= 2) ? -16'(v) : 16'(v);
    endfunction

    function automatic longint scaled_term(input longint s, input longint trig,
                                           input logic [15:0] g);
        longint prod;
        prod = s * trig * longint'(g);
        return (prod + (64'sd1 <<< 30)) >>> 31;
    endfunction

    function automatic longint clamp_bank(input longint x);
        if (x > BANK_MAX) begin
            return BANK_MAX;
        end
        if (x < BANK_MIN) begin
            return BANK_MIN;
        end
        return x;
    endfunction

    function automatic logic [39:0] floor_hypot(input longint re, input longint im);
        logic [81:0] ar, ai, total, cand;
        logic [39:0] root;
        int bitpos;
        ar    = 82'(re < 0 ? -re : re);
        ai    = 82'(im < 0 ? -im : im);
        total = ar * ar + ai * ai;
        root  = '0;
        for (bitpos = 39; bitpos >= 0; bitpos--) begin
            cand = 82'(root | (40'd1 << bitpos));
            if (cand * cand <= total) begin
                root = cand[39:0];
            end
        end
        return root;
    endfunction

    task automatic queue_word(input t_in_word wd);
        pending_words.insert(pending_words.size(), wd);
    endtask

    task automatic clear_running();
        write_pos  = 0;
        fill_count = 0;
        for (int b = 0; b < MAX_BINS; b++) begin
            phase_acc[b] = 0;
            real_sum[b]  = 0;
            imag_sum[b]  = 0;
        end
    endtask

    task automatic push_sample(input logic signed [15:0] s);
        int unsigned nb, leak, ix, ox, oi, w;
        longint re, im, old;
        nb   = (num_active > MAX_BINS) ? MAX_BINS : num_active;
        leak = (leak_q16 > LEAK_UNITY) ? LEAK_UNITY : leak_q16;
        audio_ring[write_pos] = s;
        for (int b = 0; b < nb; b++) begin
            ix = phase_acc[b] >> 22;
            w  = win_tab[b];
            re = (real_sum[b] * longint'(leak) + 32768) >>> 16;
            im = (imag_sum[b] * longint'(leak) + 32768) >>> 16;
            re = re + scaled_term(s, cos_lut[ix], gain_tab[b]);
            im = im - scaled_term(s, sin_lut[ix], gain_tab[b]);
            if (fill_count >= w) begin
                oi  = (write_pos + RING_DEPTH - w) % RING_DEPTH;
                ox  = (phase_acc[b] - back_phase[b]) >> 22;
                old = audio_ring[oi];
                re  = re - scaled_term(old, cos_lut[ox], gain_tab[b]);
                im  = im + scaled_term(old, sin_lut[ox], gain_tab[b]);
            end
            real_sum[b] = clamp_bank(re);
            imag_sum[b] = clamp_bank(im);
        end
        for (int b = 0; b < MAX_BINS; b++) begin
            phase_acc[b] = phase_acc[b] + phase_inc[b];
        end
        write_pos = (write_pos + 1) % RING_DEPTH;
        if (fill_count < RING_DEPTH - 1) begin
            fill_count++;
        end
    endtask

    task automatic apply_word(input t_in_word wd);
        int unsigned w;
        t_out_word mag;
        case (wd.opcode)
            OP_SAMPLE: begin
                push_sample(wd.sample_value);
            end
            OP_LOAD: begin
                w = wd.win_len;
                if (w < 1) begin
                    w = 1;
                end
                if (w > RING_DEPTH - 1) begin
                    w = RING_DEPTH - 1;
                end
                phase_inc[wd.bin_select]  = wd.phase_step;
                gain_tab[wd.bin_select]   = wd.bin_gain;
                win_tab[wd.bin_select]    = w;
                back_phase[wd.bin_select] = wd.phase_step * w;
                phase_acc[wd.bin_select]  = 0;
                real_sum[wd.bin_select]   = 0;
                imag_sum[wd.bin_select]   = 0;
            end
            OP_READ: begin
                mag.bin_echo  = wd.bin_select;
                mag.magnitude = floor_hypot(real_sum[wd.bin_select],
                                            imag_sum[wd.bin_select]);
                magnitudes_due.insert(magnitudes_due.size(), mag);
            end
            default: begin
                clear_running();
            end
        endcase
    endtask

    // input side: predict at the accepting edge
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready) begin
            apply_word(i_in);
            in_taken <= 1'b1;
        end else begin
            in_taken <= 1'b0;
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid  <= 1'b0;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
            if (i_in_valid && !in_taken) begin
                // hold the word until accepted
            end else if (pending_words.size() == 0 ||
                         $urandom_range(99) < send_idle_pct) begin
                i_in_valid <= 1'b0;
            end else begin
                i_in       <= pending_words[0];
                i_in_valid <= 1'b1;
                pending_words.delete(0);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (magnitudes_due.size() == 0) begin
                $error("unexpected word: bin_echo %0d magnitude %0d",
                       o_out.bin_echo, o_out.magnitude);
                error_count++;
            end else begin
                if (o_out.bin_echo !== magnitudes_due[0].bin_echo) begin
                    $error("bin_echo: expected %0d, actual %0d",
                           magnitudes_due[0].bin_echo, o_out.bin_echo);
                    error_count++;
                end
                if (o_out.magnitude !== magnitudes_due[0].magnitude) begin
                    $error("magnitude: expected %0d, actual %0d",
                           magnitudes_due[0].magnitude, o_out.magnitude);
                    error_count++;
                end
                magnitudes_due.delete(0);
            end
        end
    end

    task automatic write_reg(input logic idx, input logic [16:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        if (idx == CFG_ACTIVE_BINS) begin
            num_active = data[6:0];
        end else begin
            leak_q16 = data;
        end
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        while (pending_words.size() != 0 || i_in_valid || magnitudes_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic t_in_word random_word();
        t_in_word wd;
        int pick;
        wd.opcode        = 2'($urandom);
        wd.sample_value  = 16'($urandom);
        wd.bin_select    = 6'($urandom);
        wd.phase_step    = $urandom;
        wd.bin_gain      = 16'($urandom);
        wd.win_len       = 13'($urandom_range(0, 40));
        if ($urandom_range(19) == 0) begin
            wd.win_len = 13'($urandom);
        end
        pick = $urandom_range(99);
        if (pick < 60) begin
            wd.opcode = OP_SAMPLE;
        end else if (pick < 78) begin
            wd.opcode = OP_READ;
        end else if (pick < 97) begin
            wd.opcode = OP_LOAD;
        end else begin
            wd.opcode = OP_CLEAR;
        end
        return wd;
    endfunction

    function automatic t_in_word make_word(input logic [1:0] op, input logic [15:0] s,
                                           input logic [5:0] bin, input logic [31:0] step,
                                           input logic [15:0] g, input logic [12:0] w);
        t_in_word wd;
        wd.opcode        = op;
        wd.sample_value  = s;
        wd.bin_select    = bin;
        wd.phase_step    = step;
        wd.bin_gain      = g;
        wd.win_len       = w;
        return wd;
    endfunction

    initial begin
        logic [6:0]  bins_set [4];
        logic [16:0] leak_set [4];
        int          send_set [4];
        int          recv_set [4];
        bins_set = '{7'd64, 7'd1, 7'd127, 7'd0};
        leak_set = '{17'd65536, 17'd0, 17'd131071, 17'd61000};
        send_set = '{0, 47, 0, 31};
        recv_set = '{0, 0, 47, 31};
        for (int k = 0; k < SINE_DEPTH; k++) begin
            sin_lut[k] = sine_q15(4 * k);
            cos_lut[k] = sine_q15(4 * k + SINE_DEPTH);
        end
        for (int b = 0; b < MAX_BINS; b++) begin
            phase_inc[b]  = 0;
            gain_tab[b]   = '0;
            win_tab[b]    = 1;
            back_phase[b] = 0;
        end
        clear_running();
        num_active     = 7'd64;
        leak_q16       = LEAK_UNITY;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        i_in           = '0;
        i_in_valid     = 1'b0;
        i_out_ready    = 1'b0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = CFG_ACTIVE_BINS;
        i_cfg_data     = '0;
        i_rst_n        = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: table extremes, window clamps, sample extremes, clear
        queue_word(make_word(OP_READ, 16'h0, 6'd63, 32'h0, 16'h0, 13'd0));
        queue_word(make_word(OP_LOAD, 16'h0, 6'd0, 32'h0400_0000, 16'hFFFF, 13'd2));
        queue_word(make_word(OP_LOAD, 16'h0, 6'd63, 32'hFFFF_FFFF, 16'hFFFF, 13'd0));
        queue_word(make_word(OP_LOAD, 16'h0, 6'd5, 32'h1234_5678, 16'h8000, 13'd8191));
        queue_word(make_word(OP_LOAD, 16'h0, 6'd7, 32'h0, 16'h0, 13'd3));
        queue_word(make_word(OP_SAMPLE, 16'h7FFF, 6'd0, 32'h0, 16'h0, 13'd0));
        queue_word(make_word(OP_SAMPLE, 16'h8000, 6'd0, 32'h0, 16'h0, 13'd0));
        queue_word(make_word(OP_SAMPLE, 16'h8000, 6'd0, 32'h0, 16'h0, 13'd0));
        queue_word(make_word(OP_SAMPLE, 16'h7FFF, 6'd0, 32'h0, 16'h0, 13'd0));
        queue_word(make_word(OP_SAMPLE, 16'h0000, 6'd0, 32'h0, 16'h0, 13'd0));
        queue_word(make_word(OP_READ, 16'h0, 6'd0, 32'h0, 16'h0, 13'd0));
        queue_word(make_word(OP_READ, 16'h0, 6'd63, 32'h0, 16'h0, 13'd0));
        queue_word(make_word(OP_READ, 16'h0, 6'd5, 32'h0, 16'h0, 13'd0));
        queue_word(make_word(OP_READ, 16'h0, 6'd7, 32'h0, 16'h0, 13'd0));
        queue_word(make_word(OP_CLEAR, 16'hFFFF, 6'd0, 32'h0, 16'h0, 13'd0));
        queue_word(make_word(OP_READ, 16'h0, 6'd0, 32'h0, 16'h0, 13'd0));
        queue_word(make_word(OP_SAMPLE, 16'h4000, 6'd0, 32'h0, 16'h0, 13'd0));
        queue_word(make_word(OP_READ, 16'h0, 6'd63, 32'h0, 16'h0, 13'd0));
        wait_idle();

        for (int ph = 0; ph < 4; ph++) begin
            write_reg(CFG_ACTIVE_BINS, 17'(bins_set[ph]));
            write_reg(CFG_LEAK, leak_set[ph]);
            send_idle_pct  = send_set[ph];
            recv_stall_pct = recv_set[ph];
            for (int n = 0; n < 170; n++) begin
                queue_word(random_word());
            end
            wait_idle();
        end

        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
`default_nettype wire
